// File: hdl/sdoewv_pkg.sv
// sdoewv_pkg: types, codes and frame helpers for the sdo expedited write block
// no dependencies

`timescale 1ns / 1ps

package sdoewv_pkg;

    localparam logic [10:0] SDO_REQUEST_BASE = 11'd1536;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_RX    = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_FAIL  = 2'd2;

    localparam logic [1:0] CFG_NODE_ID     = 2'd0;
    localparam logic [1:0] CFG_TRIAL_LIMIT = 2'd1;
    localparam logic [1:0] CFG_TRIAL_TICKS = 2'd2;

    localparam logic [7:0] CMD_UPLOAD_REQ   = 8'h40;
    localparam logic [7:0] CMD_DOWNLOAD_ACK = 8'h60;
    localparam logic [7:0] CMD_ABORT        = 8'h80;
    localparam logic [7:0] CMD_EXPEDITED    = 8'h23;
    localparam logic [7:0] CMD_SIZE_MASK    = 8'h0C;
    localparam logic [7:0] CMD_XFER_MASK    = 8'h03;

    localparam int unsigned MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] obj_index;
        logic [7:0]  obj_subindex;
        logic [2:0]  size_bytes;
        logic [31:0] write_value;
        logic        verify;
        logic [7:0]  rx_command;
        logic [31:0] rx_payload;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] can_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
        logic [31:0] read_value;
        logic        abort_seen;
        logic        last;
    } out_word_t;

    function automatic out_word_t download_word(
        input logic [10:0] id,
        input logic [15:0] idx,
        input logic [7:0]  sub,
        input logic [2:0]  size,
        input logic [31:0] value
    );
        out_word_t  w;
        logic [1:0] unused;
        logic [7:0] cmd;
        unused       = 2'(3'd4 - size);
        cmd          = CMD_EXPEDITED | {4'd0, unused, 2'd0};
        w.kind       = KIND_FRAME;
        w.can_id     = id;
        w.frame_len  = 4'd4 + {1'b0, size};
        w.frame_data = {value, sub, idx[15:8], idx[7:0], cmd};
        w.read_value = '0;
        w.abort_seen = 1'b0;
        w.last       = 1'b0;
        return w;
    endfunction

    function automatic out_word_t upload_word(
        input logic [10:0] id,
        input logic [15:0] idx,
        input logic [7:0]  sub
    );
        out_word_t w;
        w.kind       = KIND_FRAME;
        w.can_id     = id;
        w.frame_len  = 4'd8;
        w.frame_data = {32'd0, sub, idx[15:8], idx[7:0], CMD_UPLOAD_REQ};
        w.read_value = '0;
        w.abort_seen = 1'b0;
        w.last       = 1'b0;
        return w;
    endfunction

    function automatic out_word_t end_word(
        input logic [1:0]  kind,
        input logic [31:0] value,
        input logic        aborted
    );
        out_word_t w;
        w.kind       = kind;
        w.can_id     = '0;
        w.frame_len  = '0;
        w.frame_data = '0;
        w.read_value = value;
        w.abort_seen = aborted;
        w.last       = 1'b0;
        return w;
    endfunction

endpackage

// File: hdl/sdo_expedited_write_verify.sv
// sdo_expedited_write_verify: sdo client for one expedited write with read-back check
// depends on sdoewv_pkg
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item: a write
//   request, a received sdo frame or a timer tick, selected by func.
//   Output channel (out_valid / out_stall) carries result words: frames to
//   transmit, write done or write failed; last marks the final word of an item.
//   Configuration (cfg_we / cfg_index / cfg_data) writes node_id, trial_limit
//   and trial_ticks; write only while the block is idle.
//   An accepted word lands in an input register and is processed in one pass
//   into a three-entry result buffer whose head drives the output port.
//   The first result word reaches the output once the item has passed from the
//   input register into the head of the result buffer.
//   An item moves into the buffer only when the buffer is empty or its last
//   word is being taken, so the buffer holds the results of one item at a time.
//   The input register takes a new word while the buffer still drains.
//   While the receiver stalls, the head word holds and the input stalls once
//   the input register is full and the buffer cannot take its results.
//   Reset clears all control state and loads the register defaults
//   (node 1, trial limit 3, trial ticks 10).

`timescale 1ns / 1ps

module sdo_expedited_write_verify
    import sdoewv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] obj_index,
    input  logic [7:0]  obj_subindex,
    input  logic [2:0]  size_bytes,
    input  logic [31:0] write_value,
    input  logic        verify,
    input  logic [7:0]  rx_command,
    input  logic [31:0] rx_payload,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [10:0] can_id,
    output logic [3:0]  frame_len,
    output logic [63:0] frame_data,
    output logic [31:0] read_value,
    output logic        abort_seen,
    output logic        last
);

    logic [6:0]  node_id_reg;
    logic [7:0]  trial_limit_reg;
    logic [15:0] trial_ticks_reg;

    logic        busy_reg, busy_next;
    logic [15:0] target_index_reg, target_index_next;
    logic [7:0]  target_subindex_reg, target_subindex_next;
    logic [31:0] target_value_reg, target_value_next;
    logic [2:0]  target_size_reg, target_size_next;
    logic [31:0] resp_value_reg, resp_value_next;
    logic        resp_aborted_reg, resp_aborted_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [7:0]  trial_count_reg, trial_count_next;

    logic        s1_valid_reg, s1_valid_next;
    in_word_t    s1_reg;

    out_word_t   res_reg [MAX_RESULTS];
    out_word_t   res_next [MAX_RESULTS];
    out_word_t   gen [MAX_RESULTS];
    logic [1:0]  res_n_reg, res_n_next;
    logic [1:0]  gen_n;

    logic        in_take;
    logic        out_take;
    logic        res_free;
    logic        move;
    logic [10:0] tx_id;
    logic [2:0]  req_size;
    logic [31:0] rx_value;
    logic [15:0] elapsed_inc;

    // handshake
    assign out_valid = (res_n_reg != 2'd0);
    assign out_take  = out_valid && !out_stall;
    assign res_free  = (res_n_reg == 2'd0) || (out_take && res_n_reg == 2'd1);
    assign move      = s1_valid_reg && res_free;
    assign in_stall  = s1_valid_reg && !res_free;
    assign in_take   = in_valid && !in_stall;

    assign kind       = res_reg[0].kind;
    assign can_id     = res_reg[0].can_id;
    assign frame_len  = res_reg[0].frame_len;
    assign frame_data = res_reg[0].frame_data;
    assign read_value = res_reg[0].read_value;
    assign abort_seen = res_reg[0].abort_seen;
    assign last       = res_reg[0].last;

    assign tx_id = SDO_REQUEST_BASE + {4'd0, node_id_reg};

    always_comb
    begin
        if (s1_reg.size_bytes == 3'd0)
            req_size = 3'd1;
        else if (s1_reg.size_bytes > 3'd4)
            req_size = 3'd4;
        else
            req_size = s1_reg.size_bytes;
    end

    // received value sized by its unused-byte count
    always_comb
    begin
        rx_value = resp_value_reg;
        if ((s1_reg.rx_command & CMD_XFER_MASK) != 8'd0)
        begin
            case (s1_reg.rx_command[3:2])
                2'd0:    rx_value = s1_reg.rx_payload;
                2'd1:    rx_value = {8'd0, s1_reg.rx_payload[23:0]};
                2'd2:    rx_value = {16'd0, s1_reg.rx_payload[15:0]};
                2'd3:    rx_value = {24'd0, s1_reg.rx_payload[7:0]};
                default: rx_value = s1_reg.rx_payload;
            endcase
        end
    end

    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;

    // one pass over the item in the input register
    always_comb
    begin
        busy_next            = busy_reg;
        target_index_next    = target_index_reg;
        target_subindex_next = target_subindex_reg;
        target_value_next    = target_value_reg;
        target_size_next     = target_size_reg;
        resp_value_next      = resp_value_reg;
        resp_aborted_next    = resp_aborted_reg;
        elapsed_next         = elapsed_reg;
        trial_count_next     = trial_count_reg;
        gen_n                = 2'd0;
        for (int i = 0; i < MAX_RESULTS; i++)
            gen[i] = end_word(KIND_DONE, 32'd0, 1'b0);

        case (s1_reg.func)
            FUNC_WRITE:
            begin
                target_index_next    = s1_reg.obj_index;
                target_subindex_next = s1_reg.obj_subindex;
                target_size_next     = req_size;
                target_value_next    = s1_reg.write_value;
                resp_value_next      = 32'd0;
                elapsed_next         = 16'd0;
                trial_count_next     = 8'd0;
                gen[0] = download_word(tx_id, s1_reg.obj_index, s1_reg.obj_subindex,
                                       req_size, s1_reg.write_value);
                gen_n  = 2'd2;
                if (!s1_reg.verify)
                begin
                    busy_next = 1'b0;
                    gen[1]    = end_word(KIND_DONE, 32'd0, resp_aborted_reg);
                end
                else
                begin
                    busy_next = 1'b1;
                    gen[1]    = upload_word(tx_id, s1_reg.obj_index, s1_reg.obj_subindex);
                end
            end
            FUNC_RX:
            begin
                resp_value_next   = rx_value;
                resp_aborted_next = ((s1_reg.rx_command & CMD_XFER_MASK) == 8'd0)
                                    && (s1_reg.rx_command == CMD_ABORT);
                if (busy_reg && s1_reg.obj_index == target_index_reg
                    && s1_reg.obj_subindex == target_subindex_reg
                    && rx_value == target_value_reg)
                begin
                    busy_next = 1'b0;
                    gen[0]    = end_word(KIND_DONE, rx_value, resp_aborted_next);
                    gen_n     = 2'd1;
                end
            end
            FUNC_TICK:
            begin
                if (busy_reg)
                begin
                    gen[0] = download_word(tx_id, target_index_reg, target_subindex_reg,
                                           target_size_reg, target_value_reg);
                    gen[1] = upload_word(tx_id, target_index_reg, target_subindex_reg);
                    gen_n  = 2'd2;
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > trial_ticks_reg)
                    begin
                        if (trial_count_reg >= trial_limit_reg)
                        begin
                            busy_next = 1'b0;
                            gen[2]    = end_word(KIND_FAIL, resp_value_reg, resp_aborted_reg);
                            gen_n     = 2'd3;
                        end
                        else
                        begin
                            if (trial_count_reg != 8'hFF)
                                trial_count_next = trial_count_reg + 8'd1;
                            elapsed_next = 16'd0;
                        end
                    end
                end
            end
            default:
            begin
                gen_n = 2'd0;
            end
        endcase

        case (gen_n)
            2'd1:    gen[0].last = 1'b1;
            2'd2:    gen[1].last = 1'b1;
            2'd3:    gen[2].last = 1'b1;
            default: gen[0].last = 1'b0;
        endcase
    end

    // result buffer, head is the output register
    always_comb
    begin
        res_n_next = res_n_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
            res_next[i] = res_reg[i];
        if (move)
        begin
            res_n_next = gen_n;
            for (int i = 0; i < MAX_RESULTS; i++)
                res_next[i] = gen[i];
        end
        else if (out_take)
        begin
            res_n_next  = res_n_reg - 2'd1;
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (move)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg     <= 7'd1;
            trial_limit_reg <= 8'd3;
            trial_ticks_reg <= 16'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NODE_ID:     node_id_reg     <= cfg_data[6:0];
                CFG_TRIAL_LIMIT: trial_limit_reg <= cfg_data[7:0];
                CFG_TRIAL_TICKS: trial_ticks_reg <= cfg_data;
                default:         node_id_reg     <= node_id_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg            <= 1'b0;
            target_index_reg    <= 16'd0;
            target_subindex_reg <= 8'd0;
            target_value_reg    <= 32'd0;
            target_size_reg     <= 3'd4;
            resp_value_reg      <= 32'd0;
            resp_aborted_reg    <= 1'b0;
            elapsed_reg         <= 16'd0;
            trial_count_reg     <= 8'd0;
        end
        else if (move)
        begin
            busy_reg            <= busy_next;
            target_index_reg    <= target_index_next;
            target_subindex_reg <= target_subindex_next;
            target_value_reg    <= target_value_next;
            target_size_reg     <= target_size_next;
            resp_value_reg      <= resp_value_next;
            resp_aborted_reg    <= resp_aborted_next;
            elapsed_reg         <= elapsed_next;
            trial_count_reg     <= trial_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            res_n_reg    <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            res_n_reg    <= res_n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_reg.func         <= func;
            s1_reg.obj_index    <= obj_index;
            s1_reg.obj_subindex <= obj_subindex;
            s1_reg.size_bytes   <= size_bytes;
            s1_reg.write_value  <= write_value;
            s1_reg.verify       <= verify;
            s1_reg.rx_command   <= rx_command;
            s1_reg.rx_payload   <= rx_payload;
        end
        for (int i = 0; i < MAX_RESULTS; i++)
            res_reg[i] <= res_next[i];
    end

    // checks
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_reg[0]))
        else $error("stalled output word changed");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> res_n_reg != 2'd0)
        else $error("write ended without a done or failed word");

    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && res_n_reg == 2'd1 |-> res_reg[0].last)
        else $error("final buffered word not marked last");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && res_n_reg != 2'd0)
        else $error("input stalled with room downstream");

endmodule

// File: tb/sdo_expedited_write_verify_tb.sv
// sdo_expedited_write_verify_tb: self-checking bench for the sdo expedited write client;
// a directed table, then random write / frame / tick sequences, each checked word by word
// depends on sdoewv_pkg and sdo_expedited_write_verify

`timescale 1ns / 1ps

module sdo_expedited_write_verify_tb
    import sdoewv_pkg::*;
();

    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         UNTYPED       = -1;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   rk;
        in_word_t    w;
        logic [1:0]  reg_index;
        logic [15:0] reg_value;
        int          n_typed;
        logic [1:0]  end_typed;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [15:0] obj_index;
    logic [7:0]  obj_subindex;
    logic [2:0]  size_bytes;
    logic [31:0] write_value;
    logic        verify;
    logic [7:0]  rx_command;
    logic [31:0] rx_payload;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [10:0] can_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic [31:0] read_value;
    logic        abort_seen;
    logic        last;

    // predictor registers and state
    logic [6:0]  m_node;
    logic [7:0]  m_limit;
    logic [15:0] m_ticks;
    logic        m_busy;
    logic [15:0] m_tgt_index;
    logic [7:0]  m_tgt_sub;
    logic [31:0] m_tgt_value;
    logic [2:0]  m_tgt_size;
    logic [15:0] m_rsp_index;
    logic [7:0]  m_rsp_sub;
    logic [31:0] m_rsp_value;
    logic        m_rsp_aborted;
    logic [15:0] m_elapsed;
    logic [7:0]  m_trials;

    out_word_t   sdo_words_due[$];
    dir_row_t    directed[$];
    int          error_count = 0;
    int          item_count  = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic [15:0] cur_idx;
    logic [7:0]  cur_sub;
    logic [31:0] cur_val;

    sdo_expedited_write_verify i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic model_reset();
        m_node        = 7'd1;
        m_limit       = 8'd3;
        m_ticks       = 16'd10;
        m_busy        = 1'b0;
        m_tgt_index   = '0;
        m_tgt_sub     = '0;
        m_tgt_value   = '0;
        m_tgt_size    = 3'd4;
        m_rsp_index   = '0;
        m_rsp_sub     = '0;
        m_rsp_value   = '0;
        m_rsp_aborted = 1'b0;
        m_elapsed     = '0;
        m_trials      = '0;
    endtask

    function automatic logic [10:0] sdo_tx_id();
        return 11'(SDO_REQUEST_BASE + {4'd0, m_node});
    endfunction

    function automatic out_word_t download_frame();
        out_word_t  f;
        logic [1:0] unused;
        f            = '0;
        unused       = 2'(3'd4 - m_tgt_size);
        f.kind       = KIND_FRAME;
        f.can_id     = sdo_tx_id();
        f.frame_len  = 4'(4 + m_tgt_size);
        f.frame_data = {m_tgt_value, m_tgt_sub, m_tgt_index,
                        8'(CMD_EXPEDITED + {4'd0, unused, 2'b00})};
        return f;
    endfunction

    function automatic out_word_t upload_frame();
        out_word_t f;
        f            = '0;
        f.kind       = KIND_FRAME;
        f.can_id     = sdo_tx_id();
        f.frame_len  = 4'd8;
        f.frame_data = {32'd0, m_tgt_sub, m_tgt_index, CMD_UPLOAD_REQ};
        return f;
    endfunction

    function automatic out_word_t outcome_word(input logic [1:0] k);
        out_word_t f;
        f            = '0;
        f.kind       = k;
        f.read_value = m_rsp_value;
        f.abort_seen = m_rsp_aborted;
        return f;
    endfunction

    // advances the predicted client by one word and queues the words it emits
    function automatic int predict_sdo_words(input in_word_t w, output logic [1:0] end_kind);
        out_word_t  produced[$];
        logic [2:0] sz;
        logic [1:0] unused;
        end_kind = KIND_FRAME;
        case (w.func)
            FUNC_WRITE:
            begin
                sz = w.size_bytes;
                if (sz == 3'd0)
                    sz = 3'd1;
                if (sz > 3'd4)
                    sz = 3'd4;
                m_tgt_index = w.obj_index;
                m_tgt_sub   = w.obj_subindex;
                m_tgt_size  = sz;
                m_tgt_value = w.write_value;
                m_rsp_index = '0;
                m_rsp_sub   = '0;
                m_rsp_value = '0;
                m_elapsed   = '0;
                m_trials    = '0;
                produced.insert(produced.size(), download_frame());
                if (!w.verify)
                begin
                    m_busy = 1'b0;
                    produced.insert(produced.size(), outcome_word(KIND_DONE));
                end
                else
                begin
                    m_busy = 1'b1;
                    produced.insert(produced.size(), upload_frame());
                end
            end
            FUNC_RX:
            begin
                m_rsp_index   = w.obj_index;
                m_rsp_sub     = w.obj_subindex;
                m_rsp_aborted = 1'b0;
                if ((w.rx_command & CMD_XFER_MASK) != 8'd0)
                begin
                    unused      = 2'((w.rx_command & CMD_SIZE_MASK) >> 2);
                    m_rsp_value = w.rx_payload & (32'hFFFF_FFFF >> {unused, 3'b000});
                end
                else if (w.rx_command == CMD_ABORT)
                    m_rsp_aborted = 1'b1;
                if (m_busy && m_rsp_index == m_tgt_index && m_rsp_sub == m_tgt_sub
                    && m_rsp_value == m_tgt_value)
                begin
                    m_busy = 1'b0;
                    produced.insert(produced.size(), outcome_word(KIND_DONE));
                end
            end
            FUNC_TICK:
            begin
                if (m_busy)
                begin
                    produced.insert(produced.size(), download_frame());
                    produced.insert(produced.size(), upload_frame());
                    if (m_elapsed != 16'hFFFF)
                        m_elapsed++;
                    if (m_elapsed > m_ticks)
                    begin
                        if (m_trials >= m_limit)
                        begin
                            m_busy = 1'b0;
                            produced.insert(produced.size(), outcome_word(KIND_FAIL));
                        end
                        else
                        begin
                            if (m_trials != 8'hFF)
                                m_trials++;
                            m_elapsed = '0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (produced.size() > 0)
        begin
            produced[produced.size() - 1].last = 1'b1;
            end_kind = produced[produced.size() - 1].kind;
        end
        foreach (produced[i])
            sdo_words_due.insert(sdo_words_due.size(), produced[i]);
        return produced.size();
    endfunction

    function automatic in_word_t make_word(input logic [1:0] f, input logic [15:0] idx,
                                           input logic [7:0] sub, input logic [2:0] sz,
                                           input logic [31:0] val, input logic vfy,
                                           input logic [7:0] cmd, input logic [31:0] pay);
        in_word_t w;
        w.func         = f;
        w.obj_index    = idx;
        w.obj_subindex = sub;
        w.size_bytes   = sz;
        w.write_value  = val;
        w.verify       = vfy;
        w.rx_command   = cmd;
        w.rx_payload   = pay;
        return w;
    endfunction

    function automatic in_word_t noise_word();
        return make_word(2'($urandom_range(3)), 16'($urandom), 8'($urandom),
                         3'($urandom), $urandom, 1'($urandom), 8'($urandom), $urandom);
    endfunction

    function automatic dir_row_t item_row(input in_word_t w, input int n, input logic [1:0] k);
        dir_row_t r;
        r.rk        = ROW_ITEM;
        r.w         = w;
        r.reg_index = '0;
        r.reg_value = '0;
        r.n_typed   = n;
        r.end_typed = k;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [15:0] val);
        dir_row_t r;
        r.rk        = ROW_CFG;
        r.w         = '0;
        r.reg_index = idx;
        r.reg_value = val;
        r.n_typed   = UNTYPED;
        r.end_typed = KIND_FRAME;
        return r;
    endfunction

    function automatic void add_row(input dir_row_t r);
        directed.insert(directed.size(), r);
    endfunction

    task automatic send_word(input in_word_t w, output int n, output logic [1:0] end_kind);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= w.func;
        obj_index    <= w.obj_index;
        obj_subindex <= w.obj_subindex;
        size_bytes   <= w.size_bytes;
        write_value  <= w.write_value;
        verify       <= w.verify;
        rx_command   <= w.rx_command;
        rx_payload   <= w.rx_payload;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        item_count++;
        n = predict_sdo_words(w, end_kind);
    endtask

    // sender holds off until every pending word is out and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (sdo_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_NODE_ID:     m_node  = val[6:0];
            CFG_TRIAL_LIMIT: m_limit = val[7:0];
            CFG_TRIAL_TICKS: m_ticks = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic random_phase(input int goal);
        in_word_t    w;
        int          n;
        int          pick;
        int          stop_at;
        logic [1:0]  ek;
        logic [1:0]  unused;
        logic [2:0]  sz;
        logic [31:0] keep_mask;
        stop_at = item_count + goal;
        while (item_count < stop_at)
        begin
            pick = $urandom_range(99);
            w    = noise_word();
            if (pick < 16)
            begin
                w.func   = FUNC_WRITE;
                w.verify = ($urandom_range(7) != 0);
                if ($urandom_range(3) != 0)
                    w.size_bytes = 3'($urandom_range(1, 4));
                sz = w.size_bytes;
                if (sz == 3'd0)
                    sz = 3'd1;
                if (sz > 3'd4)
                    sz = 3'd4;
                if ($urandom_range(1) != 0)
                    w.write_value &= 32'hFFFF_FFFF >> {2'(3'd4 - sz), 3'b000};
                cur_idx = w.obj_index;
                cur_sub = w.obj_subindex;
                cur_val = w.write_value;
            end
            else if (pick < 50)
                w.func = FUNC_TICK;
            else if (pick < 70)
            begin
                w.func         = FUNC_RX;
                w.obj_index    = cur_idx;
                w.obj_subindex = cur_sub;
                unused         = 2'($urandom_range(3));
                keep_mask      = 32'hFFFF_FFFF >> {unused, 3'b000};
                if ((cur_val & ~keep_mask) != 32'd0)
                begin
                    unused    = 2'd0;
                    keep_mask = '1;
                end
                w.rx_command[3:2] = unused;
                if (w.rx_command[1:0] == 2'b00)
                    w.rx_command[1:0] = 2'b11;
                w.rx_payload = (cur_val & keep_mask) | (w.rx_payload & ~keep_mask);
            end
            else if (pick < 78)
            begin
                w.func         = FUNC_RX;
                w.obj_index    = cur_idx;
                w.obj_subindex = cur_sub;
                w.rx_command   = ($urandom_range(1) != 0) ? CMD_ABORT : CMD_DOWNLOAD_ACK;
            end
            else if (pick < 86)
            begin
                w.func         = FUNC_RX;
                w.obj_index    = cur_idx;
                w.obj_subindex = cur_sub;
                w.rx_command   = CMD_EXPEDITED;
                w.rx_payload   = cur_val ^ (32'd1 << $urandom_range(31));
                if ($urandom_range(1) != 0)
                begin
                    w.rx_payload = cur_val;
                    w.obj_index  = cur_idx ^ (16'd1 << $urandom_range(15));
                end
            end
            else if (pick < 95)
                w.func = FUNC_RX;
            else
                w.func = FUNC_UNUSED;
            send_word(w, n, ek);
        end
    endtask

    // receiving side: random stall, each accepted word checked against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        out_word_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (sdo_words_due.size() == 0)
                    flag_error($sformatf("word with nothing pending, kind %0d", kind));
                else
                begin
                    want = sdo_words_due.pop_front();
                    if (kind !== want.kind)
                        flag_error($sformatf("kind %0d, want %0d", kind, want.kind));
                    if (can_id !== want.can_id)
                        flag_error($sformatf("can_id %h, want %h", can_id, want.can_id));
                    if (frame_len !== want.frame_len)
                        flag_error($sformatf("frame_len %0d, want %0d",
                                             frame_len, want.frame_len));
                    if (frame_data !== want.frame_data)
                        flag_error($sformatf("frame_data %h, want %h",
                                             frame_data, want.frame_data));
                    if (read_value !== want.read_value)
                        flag_error($sformatf("read_value %h, want %h",
                                             read_value, want.read_value));
                    if (abort_seen !== want.abort_seen)
                        flag_error($sformatf("abort_seen %b, want %b",
                                             abort_seen, want.abort_seen));
                    if (last !== want.last)
                        flag_error($sformatf("last %b, want %b", last, want.last));
                end
            end
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial
    begin : stimulus
        int         n;
        logic [1:0] ek;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        func         <= '0;
        obj_index    <= '0;
        obj_subindex <= '0;
        size_bytes   <= '0;
        write_value  <= '0;
        verify       <= 1'b0;
        rx_command   <= '0;
        rx_payload   <= '0;
        model_reset();
        cur_idx = '0;
        cur_sub = '0;
        cur_val = '0;

        add_row(item_row(make_word(FUNC_TICK, 16'h0, 8'h0, 3'd0, 32'h0, 1'b0,
                                   8'h0, 32'h0), 0, KIND_FRAME));
        // abort while idle stays in the response and shows on the next done
        add_row(item_row(make_word(FUNC_RX, 16'h0, 8'h0, 3'd0, 32'h0, 1'b0,
                                   CMD_ABORT, 32'h0), 0, KIND_FRAME));
        add_row(item_row(make_word(FUNC_WRITE, 16'h0, 8'h0, 3'd4, 32'h0, 1'b0,
                                   8'h0, 32'h0), 2, KIND_DONE));
        add_row(item_row(make_word(FUNC_WRITE, 16'hFFFF, 8'hFF, 3'd1,
                                   32'hFFFF_FFFF, 1'b0, 8'h0, 32'h0),
                         2, KIND_DONE));
        add_row(item_row(make_word(FUNC_WRITE, 16'h1234, 8'h01, 3'd0,
                                   32'h0000_00AB, 1'b1, 8'h0, 32'h0),
                         2, KIND_FRAME));
        add_row(item_row(make_word(FUNC_RX, 16'h1234, 8'h01, 3'd0, 32'h0, 1'b0,
                                   8'h4F, 32'hFFFF_FFAB), 1, KIND_DONE));
        add_row(item_row(make_word(FUNC_WRITE, 16'h2000, 8'h02, 3'd7,
                                   32'h1122_3344, 1'b1, 8'h0, 32'h0),
                         2, KIND_FRAME));
        add_row(item_row(make_word(FUNC_RX, 16'h2000, 8'h02, 3'd0, 32'h0, 1'b0,
                                   CMD_DOWNLOAD_ACK, 32'h1122_3344),
                         0, KIND_FRAME));
        add_row(item_row(make_word(FUNC_RX, 16'h2000, 8'h02, 3'd0, 32'h0, 1'b0,
                                   CMD_EXPEDITED, 32'h1122_3345),
                         UNTYPED, KIND_FRAME));
        // new request while busy replaces the old target
        add_row(item_row(make_word(FUNC_WRITE, 16'h3000, 8'h03, 3'd2,
                                   32'h0000_5566, 1'b1, 8'h0, 32'h0),
                         2, KIND_FRAME));
        add_row(item_row(make_word(FUNC_RX, 16'h3000, 8'h03, 3'd0, 32'h0, 1'b0,
                                   8'h4B, 32'hFFFF_5566), 1, KIND_DONE));
        add_row(item_row(make_word(FUNC_UNUSED, 16'hFFFF, 8'hFF, 3'd7,
                                   32'hFFFF_FFFF, 1'b1, 8'hFF, 32'hFFFF_FFFF),
                         0, KIND_FRAME));
        add_row(cfg_row(CFG_NODE_ID, 16'd0));
        add_row(cfg_row(CFG_TRIAL_LIMIT, 16'd0));
        add_row(cfg_row(CFG_TRIAL_TICKS, 16'd1));
        add_row(item_row(make_word(FUNC_WRITE, 16'h1017, 8'h00, 3'd2,
                                   32'h0000_03E8, 1'b1, 8'h0, 32'h0),
                         UNTYPED, KIND_FRAME));
        add_row(item_row(make_word(FUNC_TICK, 16'h0, 8'h0, 3'd0, 32'h0, 1'b0,
                                   8'h0, 32'h0), UNTYPED, KIND_FRAME));
        add_row(item_row(make_word(FUNC_RX, 16'h1017, 8'h00, 3'd0, 32'h0, 1'b0,
                                   CMD_ABORT, 32'h0), 0, KIND_FRAME));
        add_row(item_row(make_word(FUNC_TICK, 16'h0, 8'h0, 3'd0, 32'h0, 1'b0,
                                   8'h0, 32'h0), 3, KIND_FAIL));
        add_row(item_row(make_word(FUNC_TICK, 16'h0, 8'h0, 3'd0, 32'h0, 1'b0,
                                   8'h0, 32'h0), 0, KIND_FRAME));
        add_row(cfg_row(CFG_NODE_ID, 16'd127));
        add_row(cfg_row(CFG_TRIAL_LIMIT, 16'd1));
        add_row(item_row(make_word(FUNC_WRITE, 16'h6000, 8'h80, 3'd3,
                                   32'h00AB_CDEF, 1'b1, 8'h0, 32'h0),
                         UNTYPED, KIND_FRAME));
        repeat (3)
            add_row(item_row(make_word(FUNC_TICK, 16'h0, 8'h0, 3'd0, 32'h0, 1'b0,
                                       8'h0, 32'h0), UNTYPED, KIND_FRAME));
        add_row(item_row(make_word(FUNC_TICK, 16'h0, 8'h0, 3'd0, 32'h0, 1'b0,
                                   8'h0, 32'h0), 3, KIND_FAIL));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 6;
        rx_idle_pct = 70;
        foreach (directed[i])
        begin
            if (directed[i].rk == ROW_CFG)
            begin
                settle();
                write_reg(directed[i].reg_index, directed[i].reg_value);
            end
            else
            begin
                send_word(directed[i].w, n, ek);
                if (directed[i].n_typed != UNTYPED && (n != directed[i].n_typed
                    || (n > 0 && ek != directed[i].end_typed)))
                    flag_error($sformatf("row %0d gives %0d words ending in kind %0d",
                                         i, n, ek));
            end
        end

        settle();
        write_reg(CFG_NODE_ID, 16'd0);
        write_reg(CFG_TRIAL_LIMIT, 16'd0);
        write_reg(CFG_TRIAL_TICKS, 16'd1);
        random_phase(30);

        tx_idle_pct = 70;
        rx_idle_pct = 6;
        settle();
        write_reg(CFG_NODE_ID, 16'd127);
        write_reg(CFG_TRIAL_LIMIT, 16'd255);
        write_reg(CFG_TRIAL_TICKS, 16'd65535);
        random_phase(30);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (2)
        begin
            settle();
            write_reg(CFG_NODE_ID, 16'($urandom_range(127)));
            write_reg(CFG_TRIAL_LIMIT, 16'($urandom_range(3)));
            write_reg(CFG_TRIAL_TICKS, 16'($urandom_range(1, 4)));
            random_phase(20);
        end

        settle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
hdl/sdoewv_pkg.sv
hdl/sdo_expedited_write_verify.sv
tb/sdo_expedited_write_verify_tb.sv
